@@ sv/msb_pkg.sv @@
// Package for the min-id switch buffer: transaction types, command and
// result-kind codes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package msb_pkg;

  localparam int ID_W   = 31;
  localparam int CMD_W  = 2;
  localparam int PORT_W = 2;
  localparam int KIND_W = 2;
  localparam int CAP_W  = 5;

  localparam logic [CMD_W-1:0] CMD_ARRIVAL = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PERIOD  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEND    = 2'd2;
  localparam logic [CMD_W-1:0] CMD_FREE    = 2'd3;

  localparam logic [KIND_W-1:0] KIND_CREDIT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PACKET = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DROP   = 2'd2;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [PORT_W-1:0] in_port;
    logic [ID_W-1:0]   in_id;
  } in_t;

  typedef struct packed {
    logic [KIND_W-1:0] result_kind;
    logic [PORT_W-1:0] out_port;
    logic [ID_W-1:0]   out_id;
  } out_t;

endpackage

`default_nettype wire

@@ sv/msb_fifo.sv @@
// Id FIFO with a registered head word, read through a local memory.
// Standalone; the top level instantiates it for every entry queue and the exit queue.
`timescale 1ns / 1ps
`default_nettype none

module msb_fifo #(
  parameter int DEPTH = 16,
  parameter int W     = 31
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       push,
  input  wire logic                       pop,
  input  wire logic [W-1:0]               wr_data,
  output logic      [W-1:0]               head,
  output logic      [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [W-1:0]  head_r;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + AW'(1);
    end
    count_nxt = count_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // bypass the write when it lands on the next head slot
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
    if (push && (wr_ptr_r == rd_ptr_nxt)) begin
      head_r <= wr_data;
    end else begin
      head_r <= mem_r[rd_ptr_nxt];
    end
  end

  assign head  = head_r;
  assign count = count_r;

endmodule

`default_nettype wire

@@ sv/min_id_switch_buffer_top.sv @@
// Top level of the min-id switch buffer: entry queues, smallest-id arbiter,
// exit queue and channel busy flag. Uses msb_pkg and msb_fifo.
//
//   port group   direction  payload       handshake
//   in_*         input      msb_pkg::in_t  in_valid / in_stall
//   out_*        output     msb_pkg::out_t out_valid / out_stall
//   cfg_*        input      exit_capacity  cfg_wr_en, no wait
//
// One transaction per cycle while out_* is not stalled: a transaction is registered,
// then handled in one pass against the FIFO head registers and written to the result register.
// rst_n is synchronous; it empties every queue, clears busy, sets capacity 16.
// A stalled result blocks the handling stage; the input register still takes
// one more transaction behind it.
`timescale 1ns / 1ps
`default_nettype none

module min_id_switch_buffer_top #(
  parameter int NUM_PORTS   = 3,
  parameter int ENTRY_DEPTH = 16,
  parameter int EXIT_DEPTH  = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire msb_pkg::in_t                in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output msb_pkg::out_t                    out_data,
  input  wire logic                        cfg_wr_en,
  input  wire logic [msb_pkg::CAP_W-1:0]   cfg_wr_data
);

  localparam int ECW  = $clog2(ENTRY_DEPTH + 1);
  localparam int XCW  = $clog2(EXIT_DEPTH + 1);
  localparam int PIW  = $clog2(NUM_PORTS);
  localparam int CMPW = (XCW > msb_pkg::CAP_W) ? XCW : msb_pkg::CAP_W;
  localparam int IDW  = msb_pkg::ID_W;

  logic                      inq_valid_r;
  msb_pkg::in_t              inq_data_r;
  logic                      out_valid_r;
  msb_pkg::out_t             out_data_r;
  logic [msb_pkg::CAP_W-1:0] cap_r;
  logic                      busy_r, busy_nxt;

  logic                      advance;
  logic                      fire;
  logic [msb_pkg::CMD_W-1:0] cmd;

  logic [IDW-1:0]            ent_head [NUM_PORTS];
  logic [ECW-1:0]            ent_cnt  [NUM_PORTS];
  logic [NUM_PORTS-1:0]      ent_push;
  logic [NUM_PORTS-1:0]      ent_pop;
  logic [NUM_PORTS-1:0]      ent_hit;
  logic [NUM_PORTS-1:0]      ent_full;

  logic [IDW-1:0]            exit_head;
  logic [XCW-1:0]            exit_cnt;
  logic                      exit_push;
  logic                      exit_pop;
  logic                      exit_room;

  logic                      found;
  logic [PIW-1:0]            best_p;
  logic [IDW-1:0]            best_id;
  logic                      drop;
  logic                      has_res;
  msb_pkg::out_t             res;

  assign cmd      = inq_data_r.command;
  assign advance  = !(out_valid_r && out_stall);
  assign fire     = inq_valid_r && advance;
  assign in_stall = inq_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_valid_r <= 1'b0;
    end else if (!in_stall) begin
      inq_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      inq_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= msb_pkg::CAP_RESET;
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  genvar gp;
  generate
    for (gp = 0; gp < NUM_PORTS; gp++) begin : g_entry
      assign ent_hit[gp]  = (int'(inq_data_r.in_port) == gp);
      assign ent_full[gp] = (int'(ent_cnt[gp]) == ENTRY_DEPTH);
      assign ent_push[gp] = fire && (cmd == msb_pkg::CMD_ARRIVAL) && ent_hit[gp]
                            && !ent_full[gp];
      assign ent_pop[gp]  = exit_push && (best_p == PIW'(gp));

      msb_fifo #(
        .DEPTH (ENTRY_DEPTH),
        .W     (IDW)
      ) u_entry (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (ent_push[gp]),
        .pop     (ent_pop[gp]),
        .wr_data (inq_data_r.in_id),
        .head    (ent_head[gp]),
        .count   (ent_cnt[gp])
      );
    end
  endgenerate

  // smallest head wins, ties to the lowest port
  always_comb begin
    found   = 1'b0;
    best_p  = '0;
    best_id = '0;
    drop    = 1'b0;
    for (int p = 0; p < NUM_PORTS; p++) begin
      if ((ent_cnt[p] != '0) && (!found || (ent_head[p] < best_id))) begin
        found   = 1'b1;
        best_p  = PIW'(p);
        best_id = ent_head[p];
      end
      drop = drop | (ent_hit[p] & ent_full[p]);
    end
  end

  assign exit_room = (CMPW'(exit_cnt) < CMPW'(cap_r)) && (int'(exit_cnt) < EXIT_DEPTH);
  assign exit_push = fire && (cmd == msb_pkg::CMD_PERIOD) && exit_room && found;
  assign exit_pop  = fire && (cmd == msb_pkg::CMD_SEND) && (exit_cnt != '0) && !busy_r;

  msb_fifo #(
    .DEPTH (EXIT_DEPTH),
    .W     (IDW)
  ) u_exit (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (exit_push),
    .pop     (exit_pop),
    .wr_data (best_id),
    .head    (exit_head),
    .count   (exit_cnt)
  );

  always_comb begin
    has_res  = 1'b0;
    res      = '0;
    busy_nxt = busy_r;
    unique case (cmd)
      msb_pkg::CMD_ARRIVAL: begin
        has_res         = drop;
        res.result_kind = msb_pkg::KIND_DROP;
        res.out_port    = inq_data_r.in_port;
        res.out_id      = inq_data_r.in_id;
      end
      msb_pkg::CMD_PERIOD: begin
        has_res         = exit_push;
        res.result_kind = msb_pkg::KIND_CREDIT;
        res.out_port    = msb_pkg::PORT_W'(best_p);
      end
      msb_pkg::CMD_SEND: begin
        has_res         = exit_pop;
        res.result_kind = msb_pkg::KIND_PACKET;
        res.out_id      = exit_head;
        if (exit_pop) begin
          busy_nxt = 1'b1;
        end
      end
      msb_pkg::CMD_FREE: begin
        busy_nxt = 1'b0;
      end
      default: begin
        busy_nxt = busy_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (fire) begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= fire && has_res;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_one_pop : assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(ent_pop) && (exit_push == (ent_pop != '0)))
    else $error("entry pop does not match exit transfer");

  a_send_busy : assert property (@(posedge clk) disable iff (!rst_n)
    exit_pop |=> busy_r)
    else $error("channel not busy after a send");

  a_exit_bound : assert property (@(posedge clk) disable iff (!rst_n)
    (int'(exit_cnt) <= EXIT_DEPTH) && !(exit_push && (ent_push != '0)))
    else $error("exit queue overflow or conflicting queue writes");

endmodule

`default_nettype wire
